// File: rtl/periodic_timer_slot_bank_core_macros.svh
// assertion macros of the timer slot bank, used by the back end
`ifndef PERIODIC_TIMER_SLOT_BANK_CORE_MACROS_SVH
`define PERIODIC_TIMER_SLOT_BANK_CORE_MACROS_SVH

// same-cycle implication on clk, disabled while rst_n is low
`define PTSB_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication on clk, disabled while rst_n is low
`define PTSB_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/ptsb_pkg.sv
// types and constants of the periodic timer slot bank
package ptsb_pkg;

    localparam int SLOT_W      = 4;
    localparam int CB_W        = 8;
    localparam int WORD_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int NUM_SLOTS   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNREGISTER = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_REGISTER,
        OP_UNREGISTER,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] period;
        logic [CB_W-1:0]   callback;
        logic [WORD_W-1:0] ctx;
        logic              once;
        logic              direct;
        logic [SLOT_W-1:0] slot;
    } ptsb_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ptsb_qstat_t;

endpackage

// File: rtl/ptsb_front.sv
// front end: accepts input words and classifies them into operations
module ptsb_front #(
    parameter int NUM_SLOTS = ptsb_pkg::NUM_SLOTS
) (
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [ptsb_pkg::FUNC_W-1:0]   func,
    input  logic [ptsb_pkg::WORD_W-1:0]   period_ms,
    input  logic [ptsb_pkg::CB_W-1:0]     callback_id,
    input  logic [ptsb_pkg::WORD_W-1:0]   context_req,
    input  logic                          one_shot,
    input  logic                          call_direct,
    input  logic [ptsb_pkg::SLOT_W-1:0]   slot,
    input  ptsb_pkg::ptsb_qstat_t         q_stat,
    output logic                          push,
    output ptsb_pkg::ptsb_word_t          push_word
);

    logic slot_in_range;

    assign slot_in_range = ({1'b0, slot} < (ptsb_pkg::SLOT_W+1)'(NUM_SLOTS));
    assign item_stall    = q_stat.full;
    assign push          = item_valid && !q_stat.full;

    always_comb
    begin
        push_word.period   = period_ms;
        push_word.callback = callback_id;
        push_word.ctx      = context_req;
        push_word.once     = one_shot;
        push_word.direct   = call_direct;
        push_word.slot     = slot;
        case (func)
            ptsb_pkg::FUNC_TICK:       push_word.op = ptsb_pkg::OP_TICK;
            ptsb_pkg::FUNC_REGISTER:   push_word.op = ptsb_pkg::OP_REGISTER;
            // freeing a slot outside the bank does nothing
            ptsb_pkg::FUNC_UNREGISTER: push_word.op = slot_in_range ?
                                           ptsb_pkg::OP_UNREGISTER : ptsb_pkg::OP_NOP;
            default:                   push_word.op = ptsb_pkg::OP_NOP;
        endcase
    end

endmodule

// File: rtl/ptsb_queue.sv
// short word queue between the front end and the slot bank
module ptsb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ptsb_pkg::ptsb_word_t  push_word,
    input  logic                  pop,
    output ptsb_pkg::ptsb_word_t  pop_word,
    output ptsb_pkg::ptsb_qstat_t q_stat
);

    localparam int DEPTH = ptsb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptsb_pkg::ptsb_word_t store_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_word     = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: rtl/ptsb_back.sv
// back end: slot bank, tick counter and result register
`include "periodic_timer_slot_bank_core_macros.svh"

module ptsb_back #(
    parameter int NUM_SLOTS = ptsb_pkg::NUM_SLOTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ptsb_pkg::ptsb_qstat_t           q_stat,
    input  ptsb_pkg::ptsb_word_t            pop_word,
    output logic                            pop,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            fired,
    output logic [ptsb_pkg::SLOT_W-1:0]     fired_slot,
    output logic [ptsb_pkg::CB_W-1:0]       fired_callback,
    output logic [ptsb_pkg::WORD_W-1:0]     fired_context,
    output logic                            fired_direct,
    output logic [ptsb_pkg::STATUS_W-1:0]   reg_status,
    output logic [ptsb_pkg::SLOT_W-1:0]     reg_slot,
    output logic [ptsb_pkg::WORD_W-1:0]     time_now
);

    localparam int N      = NUM_SLOTS;
    localparam int SLOT_W = ptsb_pkg::SLOT_W;
    localparam int CB_W   = ptsb_pkg::CB_W;
    localparam int WORD_W = ptsb_pkg::WORD_W;

    logic [N-1:0]      active_reg, active_next;
    logic [N-1:0]      once_reg, direct_reg;
    logic [CB_W-1:0]   cb_reg     [N];
    logic [WORD_W-1:0] ctx_reg    [N];
    logic [WORD_W-1:0] period_reg [N];
    logic [WORD_W-1:0] rem_reg    [N];
    logic [WORD_W-1:0] rem_next   [N];
    logic [WORD_W-1:0] tick_count_reg, tick_count_next;

    logic [N-1:0] hit_vec, fire_vec, before_mask, free_vec, claim_vec, dup_vec;
    logic         dup, full, reg_ok;
    logic         take, is_tick, is_reg, is_unreg;

    logic                  result_valid_reg;
    logic                  fired_reg, fired_next;
    logic [SLOT_W-1:0]     fired_slot_reg, fired_slot_next;
    logic [CB_W-1:0]       fired_cb_reg, fired_cb_next;
    logic [WORD_W-1:0]     fired_ctx_reg, fired_ctx_next;
    logic                  fired_dir_reg, fired_dir_next;
    logic [ptsb_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]     reg_slot_reg, reg_slot_next;

    assign take     = !q_stat.empty && (!result_valid_reg || !result_stall);
    assign pop      = take;
    assign is_tick  = take && (pop_word.op == ptsb_pkg::OP_TICK);
    assign is_reg   = take && (pop_word.op == ptsb_pkg::OP_REGISTER);
    assign is_unreg = take && (pop_word.op == ptsb_pkg::OP_UNREGISTER);

    // per-slot compares
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            hit_vec[i] = active_reg[i] && (rem_reg[i] == WORD_W'(1));
            dup_vec[i] = active_reg[i] && (cb_reg[i] == pop_word.callback)
                         && (rem_reg[i] == pop_word.period);
        end
    end

    // lowest expiring slot, and the slots before it that count down
    assign fire_vec    = hit_vec & (~hit_vec + N'(1));
    assign before_mask = fire_vec - N'(1);
    assign free_vec    = ~active_reg;
    assign claim_vec   = free_vec & (~free_vec + N'(1));
    assign dup         = |dup_vec;
    assign full        = ~|free_vec;
    assign reg_ok      = !dup && !full;

    always_comb
    begin
        active_next     = active_reg;
        tick_count_next = tick_count_reg;
        for (int i = 0; i < N; i++)
        begin
            rem_next[i] = rem_reg[i];
        end
        if (is_tick)
        begin
            tick_count_next = tick_count_reg + WORD_W'(1);
            active_next     = active_reg & ~(fire_vec & once_reg);
            for (int i = 0; i < N; i++)
            begin
                if (fire_vec[i])
                begin
                    rem_next[i] = period_reg[i];
                end
                else if (active_reg[i] && before_mask[i])
                begin
                    rem_next[i] = rem_reg[i] - WORD_W'(1);
                end
            end
        end
        else if (is_reg && reg_ok)
        begin
            active_next = active_reg | claim_vec;
            for (int i = 0; i < N; i++)
            begin
                if (claim_vec[i])
                begin
                    rem_next[i] = pop_word.period;
                end
            end
        end
        else if (is_unreg)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (pop_word.slot == SLOT_W'(i))
                begin
                    active_next[i] = 1'b0;
                end
            end
        end
    end

    // result fields
    always_comb
    begin
        fired_next      = 1'b0;
        fired_slot_next = '0;
        fired_cb_next   = '0;
        fired_ctx_next  = '0;
        fired_dir_next  = 1'b0;
        status_next     = ptsb_pkg::STATUS_OK;
        reg_slot_next   = '0;
        if (is_tick)
        begin
            fired_next = |fire_vec;
            for (int i = 0; i < N; i++)
            begin
                if (fire_vec[i])
                begin
                    fired_slot_next = fired_slot_next | SLOT_W'(i);
                    fired_cb_next   = fired_cb_next | cb_reg[i];
                    fired_ctx_next  = fired_ctx_next | ctx_reg[i];
                    fired_dir_next  = fired_dir_next | direct_reg[i];
                end
            end
        end
        else if (is_reg)
        begin
            if (dup)
            begin
                status_next = ptsb_pkg::STATUS_DUP;
            end
            else if (full)
            begin
                status_next = ptsb_pkg::STATUS_FULL;
            end
            else
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (claim_vec[i])
                    begin
                        reg_slot_next = reg_slot_next | SLOT_W'(i);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= '0;
            tick_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            tick_count_reg <= tick_count_next;
            if (take)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            rem_reg[i] <= rem_next[i];
            if (is_reg && reg_ok && claim_vec[i])
            begin
                cb_reg[i]     <= pop_word.callback;
                ctx_reg[i]    <= pop_word.ctx;
                period_reg[i] <= pop_word.period;
                once_reg[i]   <= pop_word.once;
                direct_reg[i] <= pop_word.direct;
            end
        end
        if (take)
        begin
            fired_reg      <= fired_next;
            fired_slot_reg <= fired_slot_next;
            fired_cb_reg   <= fired_cb_next;
            fired_ctx_reg  <= fired_ctx_next;
            fired_dir_reg  <= fired_dir_next;
            status_reg     <= status_next;
            reg_slot_reg   <= reg_slot_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign fired          = fired_reg;
    assign fired_slot     = fired_slot_reg;
    assign fired_callback = fired_cb_reg;
    assign fired_context  = fired_ctx_reg;
    assign fired_direct   = fired_dir_reg;
    assign reg_status     = status_reg;
    assign reg_slot       = reg_slot_reg;
    assign time_now       = tick_count_reg;

    `PTSB_ASSERT_IMPLY(a_fire_onehot, 1'b1, $onehot0(fire_vec), "more than one slot fires")
    `PTSB_ASSERT_NEXT(a_claim_one, is_reg && reg_ok,
        $countones(active_reg) == $past($countones(active_reg)) + 1, "claim did not add a slot")
    `PTSB_ASSERT_NEXT(a_tick_step, is_tick,
        tick_count_reg == $past(tick_count_reg) + WORD_W'(1), "tick counter did not advance")
    `PTSB_ASSERT_IMPLY(a_fire_no_status, result_valid_reg && fired_reg,
        status_reg == ptsb_pkg::STATUS_OK && reg_slot_reg == '0, "fired word has register status")

endmodule

// File: rtl/periodic_timer_slot_bank_core.sv
// top level of the periodic timer slot bank
// A bank of NUM_SLOTS timer slots driven by tick, register and unregister words. The block
// takes one word per cycle while item_stall is low and returns one result word for each, in
// order; a word is written into the front queue, the slot bank takes it from there, on a tick
// counts down the active slots up to the lowest expiring one and picks that one, and the
// result register loads the result that is then offered. A two-word queue lets the input
// side keep going while a result waits on a stalled output. After reset all slots are free
// and the tick counter is zero; no clearing pass is needed.
module periodic_timer_slot_bank_core #(
    parameter int NUM_SLOTS = ptsb_pkg::NUM_SLOTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [ptsb_pkg::FUNC_W-1:0]     func,
    input  logic [ptsb_pkg::WORD_W-1:0]     period_ms,
    input  logic [ptsb_pkg::CB_W-1:0]       callback_id,
    input  logic [ptsb_pkg::WORD_W-1:0]     context_req,
    input  logic                            one_shot,
    input  logic                            call_direct,
    input  logic [ptsb_pkg::SLOT_W-1:0]     slot,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            fired,
    output logic [ptsb_pkg::SLOT_W-1:0]     fired_slot,
    output logic [ptsb_pkg::CB_W-1:0]       fired_callback,
    output logic [ptsb_pkg::WORD_W-1:0]     fired_context,
    output logic                            fired_direct,
    output logic [ptsb_pkg::STATUS_W-1:0]   reg_status,
    output logic [ptsb_pkg::SLOT_W-1:0]     reg_slot,
    output logic [ptsb_pkg::WORD_W-1:0]     time_now
);

    ptsb_pkg::ptsb_qstat_t q_stat;
    ptsb_pkg::ptsb_word_t  push_word, pop_word;
    logic                  push, pop;

    ptsb_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .func        (func),
        .period_ms   (period_ms),
        .callback_id (callback_id),
        .context_req (context_req),
        .one_shot    (one_shot),
        .call_direct (call_direct),
        .slot        (slot),
        .q_stat      (q_stat),
        .push        (push),
        .push_word   (push_word)
    );

    ptsb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .q_stat    (q_stat)
    );

    ptsb_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .pop_word       (pop_word),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .fired          (fired),
        .fired_slot     (fired_slot),
        .fired_callback (fired_callback),
        .fired_context  (fired_context),
        .fired_direct   (fired_direct),
        .reg_status     (reg_status),
        .reg_slot       (reg_slot),
        .time_now       (time_now)
    );

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the periodic timer slot bank core
module tb_top;
    import ptsb_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int BACKLOG_HOLD = 300;
    localparam int BACKLOG_AT   = 600;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        logic                fired;
        logic [SLOT_W-1:0]   fired_slot;
        logic [CB_W-1:0]     fired_callback;
        logic [WORD_W-1:0]   fired_context;
        logic                fired_direct;
        logic [STATUS_W-1:0] reg_status;
        logic [SLOT_W-1:0]   reg_slot;
        logic [WORD_W-1:0]   time_now;
    } timer_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic [FUNC_W-1:0]   func = '0;
    logic [WORD_W-1:0]   period_ms = '0;
    logic [CB_W-1:0]     callback_id = '0;
    logic [WORD_W-1:0]   context_req = '0;
    logic                one_shot = 1'b0;
    logic                call_direct = 1'b0;
    logic [SLOT_W-1:0]   slot = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic                fired;
    logic [SLOT_W-1:0]   fired_slot;
    logic [CB_W-1:0]     fired_callback;
    logic [WORD_W-1:0]   fired_context;
    logic                fired_direct;
    logic [STATUS_W-1:0] reg_status;
    logic [SLOT_W-1:0]   reg_slot;
    logic [WORD_W-1:0]   time_now;

    // shadow of the slot bank
    logic                bank_active [NUM_SLOTS] = '{default: 1'b0};
    logic [CB_W-1:0]     bank_cb     [NUM_SLOTS];
    logic [WORD_W-1:0]   bank_ctx    [NUM_SLOTS];
    logic [WORD_W-1:0]   bank_period [NUM_SLOTS];
    logic [WORD_W-1:0]   bank_left   [NUM_SLOTS];
    logic                bank_once   [NUM_SLOTS];
    logic                bank_direct [NUM_SLOTS];
    logic [WORD_W-1:0]   tick_count = '0;

    ptsb_word_t          pending_words [$];
    timer_result_t       expected_results [$];
    ptsb_word_t          bus_word = '0;
    timer_result_t       want_in;
    timer_result_t       want_out;

    logic                in_taken = 1'b0;
    logic                out_taken = 1'b0;
    bit                  in_quiet = 1'b0;
    bit                  out_quiet = 1'b0;
    bit                  backlog_done = 1'b0;
    int                  gap_left = 0;
    int                  hold_left = 0;
    int                  words_taken = 0;
    int                  results_seen = 0;
    int                  mismatches = 0;
    int                  idle_cycles = 0;

    periodic_timer_slot_bank_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .func           (func),
        .period_ms      (period_ms),
        .callback_id    (callback_id),
        .context_req    (context_req),
        .one_shot       (one_shot),
        .call_direct    (call_direct),
        .slot           (slot),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .fired          (fired),
        .fired_slot     (fired_slot),
        .fired_callback (fired_callback),
        .fired_context  (fired_context),
        .fired_direct   (fired_direct),
        .reg_status     (reg_status),
        .reg_slot       (reg_slot),
        .time_now       (time_now)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic timer_bank_step(input ptsb_word_t w, output timer_result_t r);
        logic              hit;
        logic              have_free;
        logic              dup;
        logic [SLOT_W-1:0] free_idx;
        r = '0;
        hit = 1'b0;
        have_free = 1'b0;
        dup = 1'b0;
        free_idx = '0;
        case (w.op)
            OP_TICK:
            begin
                tick_count = tick_count + 32'd1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!hit && bank_active[i])
                    begin
                        bank_left[i] = bank_left[i] - 32'd1;
                        if (bank_left[i] == '0)
                        begin
                            bank_left[i] = bank_period[i];
                            hit = 1'b1;
                            r.fired = 1'b1;
                            r.fired_slot = SLOT_W'(i);
                            r.fired_callback = bank_cb[i];
                            r.fired_context = bank_ctx[i];
                            r.fired_direct = bank_direct[i];
                            if (bank_once[i])
                                bank_active[i] = 1'b0;
                        end
                    end
                end
            end
            OP_REGISTER:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!bank_active[i])
                    begin
                        if (!have_free)
                        begin
                            have_free = 1'b1;
                            free_idx = SLOT_W'(i);
                        end
                    end
                    else if (bank_cb[i] == w.callback && bank_left[i] == w.period)
                        dup = 1'b1;
                end
                if (dup)
                    r.reg_status = STATUS_DUP;
                else if (!have_free)
                    r.reg_status = STATUS_FULL;
                else
                begin
                    bank_active[free_idx] = 1'b1;
                    bank_cb[free_idx] = w.callback;
                    bank_ctx[free_idx] = w.ctx;
                    bank_period[free_idx] = w.period;
                    bank_left[free_idx] = w.period;
                    bank_once[free_idx] = w.once;
                    bank_direct[free_idx] = w.direct;
                    r.reg_status = STATUS_OK;
                    r.reg_slot = free_idx;
                end
            end
            OP_UNREGISTER:
            begin
                if (int'(w.slot) < NUM_SLOTS)
                    bank_active[w.slot] = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.time_now = tick_count;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_word(input op_t op, input logic [WORD_W-1:0] period,
                            input logic [CB_W-1:0] cb, input logic [WORD_W-1:0] ctx,
                            input logic once, input logic direct,
                            input logic [SLOT_W-1:0] sel);
        ptsb_word_t w;
        w.op = op;
        w.period = period;
        w.callback = cb;
        w.ctx = ctx;
        w.once = once;
        w.direct = direct;
        w.slot = sel;
        pending_words.push_back(w);
    endtask

    function automatic ptsb_word_t random_word(input int reg_pct, input int unreg_pct);
        ptsb_word_t w;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            w.op = OP_NOP;
        else if (pick < 4 + reg_pct)
            w.op = OP_REGISTER;
        else if (pick < 4 + reg_pct + unreg_pct)
            w.op = OP_UNREGISTER;
        else
            w.op = OP_TICK;
        case ($urandom_range(0, 9))
            0: w.period = $urandom;
            1: w.period = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: w.period = $urandom_range(1, 12);
        endcase
        if ($urandom_range(0, 4) == 0)
            w.callback = CB_W'($urandom_range(0, 255));
        else
            w.callback = CB_W'($urandom_range(1, 4));
        w.ctx = $urandom;
        w.once = 1'($urandom_range(0, 1));
        w.direct = 1'($urandom_range(0, 1));
        w.slot = SLOT_W'($urandom_range(0, 15));
        return w;
    endfunction

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n && !(item_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                item_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_words.size() > 0)
            begin
                bus_word = pending_words.pop_front();
                func <= bus_word.op;
                period_ms <= bus_word.period;
                callback_id <= bus_word.callback;
                context_req <= bus_word.ctx;
                one_shot <= bus_word.once;
                call_direct <= bus_word.direct;
                slot <= bus_word.slot;
                item_valid <= 1'b1;
                gap_left = draw_wait(in_quiet);
                if ($urandom_range(0, 63) == 0)
                    in_quiet = !in_quiet;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver stall, with one long backlog stretch
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                if (!backlog_done && results_seen >= BACKLOG_AT)
                begin
                    hold_left = BACKLOG_HOLD;
                    backlog_done = 1'b1;
                end
                else
                    hold_left = draw_wait(out_quiet);
                if ($urandom_range(0, 63) == 0)
                    out_quiet = !out_quiet;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= item_valid && !item_stall;
            out_taken <= result_valid && !result_stall;
            idle_cycles <= ((item_valid && !item_stall) || (result_valid && !result_stall)) ?
                           0 : idle_cycles + 1;
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want_out = expected_results.pop_front();
                    check_field("fired", want_out.fired, fired);
                    check_field("fired_slot", want_out.fired_slot, fired_slot);
                    check_field("fired_callback", want_out.fired_callback, fired_callback);
                    check_field("fired_context", want_out.fired_context, fired_context);
                    check_field("fired_direct", want_out.fired_direct, fired_direct);
                    check_field("reg_status", want_out.reg_status, reg_status);
                    check_field("reg_slot", want_out.reg_slot, reg_slot);
                    check_field("time_now", want_out.time_now, time_now);
                end
            end
            if (item_valid && !item_stall)
            begin
                words_taken++;
                timer_bank_step(bus_word, want_in);
                expected_results.push_back(want_in);
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int reg_pct;
        int unreg_pct;
        int total;

        // empty bank, idle op, then a period-one slot and a plain duplicate
        add_word(OP_TICK, 32'h0, 8'h0, 32'h0, 1'b0, 1'b0, 4'h0);
        add_word(OP_NOP, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'hF);
        add_word(OP_REGISTER, 32'd1, 8'd1, 32'hFFFF_FFFF, 1'b0, 1'b1, 4'h0);
        add_word(OP_TICK, 32'h0, 8'h0, 32'h0, 1'b0, 1'b0, 4'h0);
        add_word(OP_REGISTER, 32'd1, 8'd1, 32'h1234_5678, 1'b0, 1'b0, 4'h0);
        // callback id zero, period zero, widest period
        add_word(OP_REGISTER, 32'd2, 8'h00, 32'h0, 1'b1, 1'b0, 4'h0);
        add_word(OP_REGISTER, 32'h0, 8'hFF, 32'hA5A5_A5A5, 1'b0, 1'b1, 4'h0);
        add_word(OP_REGISTER, 32'hFFFF_FFFF, 8'h80, 32'h5A5A_5A5A, 1'b1, 1'b1, 4'h0);
        add_word(OP_TICK, 32'h0, 8'h0, 32'h0, 1'b0, 1'b0, 4'h0);
        add_word(OP_UNREGISTER, 32'h0, 8'h0, 32'h0, 1'b0, 1'b0, 4'h0);
        add_word(OP_TICK, 32'h0, 8'h0, 32'h0, 1'b0, 1'b0, 4'h0);
        add_word(OP_TICK, 32'h0, 8'h0, 32'h0, 1'b0, 1'b0, 4'h0);
        // slot one is free again after its one-shot firing
        add_word(OP_UNREGISTER, 32'h0, 8'h0, 32'h0, 1'b0, 1'b0, 4'h1);
        // fill the bank, then duplicate while full, then plain full
        for (int i = 0; i < 14; i++)
            add_word(OP_REGISTER, 32'd1000 + i, CB_W'(16 + i), $urandom, 1'(i), 1'(i >> 1),
                     4'h0);
        add_word(OP_REGISTER, 32'd1000, 8'h10, 32'h0, 1'b0, 1'b0, 4'h0);
        add_word(OP_REGISTER, 32'd5, 8'h77, 32'h0, 1'b0, 1'b0, 4'h0);
        add_word(OP_UNREGISTER, 32'h0, 8'h0, 32'h0, 1'b0, 1'b0, 4'hF);

        for (int b = 0; b < 35; b++)
        begin
            case ($urandom_range(0, 2))
                0: begin reg_pct = 15; unreg_pct = 10; end
                1: begin reg_pct = 35; unreg_pct = 5; end
                default: begin reg_pct = 10; unreg_pct = 30; end
            endcase
            for (int k = 0; k < 50; k++)
                pending_words.push_back(random_word(reg_pct, unreg_pct));
        end
        total = pending_words.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_taken < total || expected_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
